// ===== hw/rtl/bas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array stack package
// Types, codes and sizing constants shared by the stack core and its cells.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CMP_W      = (CNT_W > 9) ? CNT_W : 9;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [1:0]
    {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2,
        STS_BADINDEX  = 2'd3
    } status_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_PEEK = 1'b1
    } state_t;

    typedef enum logic [1:0]
    {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2
    } cell_op_t;

    typedef struct packed
    {
        cell_op_t op;
        logic     lane_load;
        logic     lane_shift;
    } cell_ctrl_t;

    typedef struct packed
    {
        logic [1:0]         cmd;
        logic signed [31:0] push_value;
        logic [8:0]         position;
    } req_beat_t;

    typedef struct packed
    {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               is_empty;
        logic               is_full;
    } rsp_beat_t;

    function automatic logic [31:0] to_data(input word_t w);
        return 32'(w);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bounded_array_stack_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array stack core
// A LIFO stack of signed words held in a row of cells, top entry in the
// first cell, with push, pop and peek by position from the top.
// ----------------------------------------------------------------------------
//  channel    handshake                  beat / data
//  request    req_valid, req_stall       req (cmd, push_value, position)
//  response   rsp_valid, rsp_stall       rsp (data, status, is_empty, is_full)
//  capacity   capacity_we                capacity_data
//
// Push, pop, no-op and rejected peeks need no lane walk through the cells.
// A peek at position p loads the lane, shifts it up p - 1 times
// through the cells, and returns the top lane word.
// Reset clears the entry count and sets the capacity to 256; cells are not cleared.
// Results wait in an output register with one holding slot behind it; requests
// are stalled while a peek walks the lane or while the holding slot is full.
// ----------------------------------------------------------------------------
module bounded_array_stack_core
    import bas_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       capacity_we,
    input  wire logic [8:0] capacity_data,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_beat_t  req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_beat_t       rsp
);

    cell_ctrl_t cell_ctrl;
    word_t      push_word;
    word_t      word_w [DEPTH];
    word_t      lane_w [DEPTH];

    bas_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity_we   (capacity_we),
        .capacity_data (capacity_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .top_word      (word_w[0]),
        .top_lane      (lane_w[0]),
        .cell_ctrl     (cell_ctrl),
        .push_word     (push_word)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t above;
        word_t below;
        word_t lane_in;

        if (i == 0)
        begin : g_first
            assign above = push_word;
        end
        else
        begin : g_mid_above
            assign above = word_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign below   = '0;
            assign lane_in = '0;
        end
        else
        begin : g_mid_below
            assign below   = word_w[i+1];
            assign lane_in = lane_w[i+1];
        end

        bas_cell u_cell
        (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .word_above (above),
            .word_below (below),
            .lane_below (lane_in),
            .word       (word_w[i]),
            .lane       (lane_w[i])
        );
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bas_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array stack cell
// Holds one stack entry and one word of the peek lane, and trades both with
// its neighbours as the controller commands.
// ----------------------------------------------------------------------------
module bas_cell
    import bas_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire word_t      word_above,
    input  wire word_t      word_below,
    input  wire word_t      lane_below,
    output word_t           word,
    output word_t           lane
);

    word_t word_reg;
    word_t word_next;
    word_t lane_reg;
    word_t lane_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_PUSH: word_next = word_above;
            CELL_POP:  word_next = word_below;
            default:   word_next = word_reg;
        endcase
        if (ctrl.lane_load)
        begin
            lane_next = word_reg;
        end
        else if (ctrl.lane_shift)
        begin
            lane_next = lane_below;
        end
        else
        begin
            lane_next = lane_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        lane_reg <= lane_next;
    end

    assign word = word_reg;
    assign lane = lane_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bas_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array stack controller
// Keeps the entry count and capacity, sequences peeks along the lane and
// holds results in an output register with one holding slot behind it.
// ----------------------------------------------------------------------------
module bas_ctrl
    import bas_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       capacity_we,
    input  wire logic [8:0] capacity_data,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_beat_t  req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_beat_t       rsp,
    input  wire word_t      top_word,
    input  wire word_t      top_lane,
    output cell_ctrl_t      cell_ctrl,
    output word_t           push_word
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] shift_reg;
    logic [IDX_W-1:0] shift_next;
    logic [8:0]       cap_reg;
    logic [8:0]       cap_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_beat_t        rsp_beat_reg;
    rsp_beat_t        rsp_beat_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    rsp_beat_t        pend_beat_reg;
    rsp_beat_t        pend_beat_next;

    logic             accept;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic             full_now;
    logic             pos_ok;
    logic             res_valid;
    rsp_beat_t        res;
    logic             rsp_free;

    assign req_stall = (state_reg != ST_IDLE) || pend_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign push_word = DATA_WIDTH'(req.push_value);
    assign cap_ext   = CMP_W'(cap_reg);
    assign eff_cap   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign pos_ext   = CMP_W'(req.position);
    assign full_now  = cnt_ext >= eff_cap;
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign cap_next  = capacity_we ? capacity_data : cap_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_PEEK) && pos_ok)
                begin
                    state_next = ST_PEEK;
                end
            end
            ST_PEEK:
            begin
                if (shift_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.lane_load  = 1'b0;
        cell_ctrl.lane_shift = 1'b0;
        cnt_next             = cnt_reg;
        shift_next           = shift_reg;
        res_valid            = 1'b0;
        res.data             = '0;
        res.status           = STS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_PUSH:
                        begin
                            res_valid = 1'b1;
                            if (full_now)
                            begin
                                res.status = STS_OVERFLOW;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_PUSH;
                                cnt_next     = cnt_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            res_valid = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                res.status = STS_UNDERFLOW;
                                res.data   = to_data({DATA_WIDTH{1'b1}});
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_POP;
                                cnt_next     = cnt_reg - 1'b1;
                                res.data     = to_data(top_word);
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (pos_ok)
                            begin
                                cell_ctrl.lane_load = 1'b1;
                                shift_next          = IDX_W'(pos_ext - 1'b1);
                            end
                            else
                            begin
                                res_valid  = 1'b1;
                                res.status = STS_BADINDEX;
                                res.data   = to_data({DATA_WIDTH{1'b1}});
                            end
                        end
                        default: res_valid = 1'b1;
                    endcase
                end
            end
            ST_PEEK:
            begin
                if (shift_reg == '0)
                begin
                    res_valid = 1'b1;
                    res.data  = to_data(top_lane);
                end
                else
                begin
                    cell_ctrl.lane_shift = 1'b1;
                    shift_next           = shift_reg - 1'b1;
                end
            end
            default: ;
        endcase
        res.is_empty = (cnt_next == '0);
        res.is_full  = CMP_W'(cnt_next) >= eff_cap;
    end

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_beat_next   = rsp_beat_reg;
        pend_valid_next = pend_valid_reg;
        pend_beat_next  = pend_beat_reg;
        if (res_valid)
        begin
            if (rsp_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_beat_next  = res;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_beat_next  = res;
            end
        end
        else if (pend_valid_reg && rsp_free)
        begin
            rsp_valid_next  = 1'b1;
            rsp_beat_next   = pend_beat_reg;
            pend_valid_next = 1'b0;
        end
        else if (rsp_free)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            shift_reg      <= '0;
            cap_reg        <= 9'd256;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            shift_reg      <= shift_next;
            cap_reg        <= cap_next;
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_beat_reg  <= rsp_beat_next;
        pend_beat_reg <= pend_beat_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_beat_reg;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array stack core testbench
// Drives push, pop, peek and no-op beats into the stack core under random
// idling on both channels and several capacity settings, and compares each
// response beat field by field with a behavioural stack kept alongside. A
// short directed table covers the empty, full and error cases first.
// ----------------------------------------------------------------------------
module tb_top;
    import bas_pkg::*;

    localparam logic [31:0] ERR_WORD = 32'hFFFF_FFFF;
    localparam rsp_beat_t   NO_RSP   = '0;

    typedef struct
    {
        bit         set_cap;
        logic [8:0] cap;
        req_beat_t  beat;
        bit         typed;
        rsp_beat_t  want;
    } dir_row_t;

    typedef struct
    {
        int cap;
        int beats;
        int push_pct;
        int pop_pct;
        int peek_pct;
    } phase_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       capacity_we   = 1'b0;
    logic [8:0] capacity_data = '0;
    logic       req_valid     = 1'b0;
    logic       req_stall;
    req_beat_t  req           = '0;
    logic       rsp_valid;
    logic       rsp_stall     = 1'b0;
    rsp_beat_t  rsp;

    logic [31:0] shadow_words [DEPTH];
    int          shadow_count = 0;
    logic [8:0]  shadow_cap   = 9'd256;
    rsp_beat_t   pending_rsp [$];
    int          mismatches   = 0;
    int          rsp_seen     = 0;
    int          stall_left   = 0;
    bit          send_quiet   = 1'b0;
    bit          rsp_quiet    = 1'b0;

    dir_row_t dir_rows [20] = '{
        '{0, 9'd0,   '{CMD_POP,  32'h0000_0000, 9'd0},   1, '{ERR_WORD, STS_UNDERFLOW, 1'b1, 1'b0}},
        '{0, 9'd0,   '{CMD_PEEK, 32'h0000_0000, 9'd1},   1, '{ERR_WORD, STS_BADINDEX, 1'b1, 1'b0}},
        '{0, 9'd0,   '{CMD_NOP,  32'hFFFF_FFFF, 9'h1FF}, 1, '{32'd0, STS_OK, 1'b1, 1'b0}},
        '{1, 9'd0,   '{CMD_PUSH, 32'h0000_0005, 9'd0},   1, '{32'd0, STS_OVERFLOW, 1'b1, 1'b1}},
        '{1, 9'd2,   '{CMD_PUSH, 32'h7FFF_FFFF, 9'd0},   1, '{32'd0, STS_OK, 1'b0, 1'b0}},
        '{0, 9'd0,   '{CMD_PUSH, 32'h8000_0000, 9'd0},   1, '{32'd0, STS_OK, 1'b0, 1'b1}},
        '{0, 9'd0,   '{CMD_PUSH, 32'hFFFF_FFFF, 9'd0},   1, '{32'd0, STS_OVERFLOW, 1'b0, 1'b1}},
        '{0, 9'd0,   '{CMD_PEEK, 32'h0000_0000, 9'd0},   1, '{ERR_WORD, STS_BADINDEX, 1'b0, 1'b1}},
        '{0, 9'd0,   '{CMD_PEEK, 32'h0000_0000, 9'd1},   0, NO_RSP},
        '{0, 9'd0,   '{CMD_PEEK, 32'h0000_0000, 9'd2},   0, NO_RSP},
        '{0, 9'd0,   '{CMD_PEEK, 32'h0000_0000, 9'd3},   1, '{ERR_WORD, STS_BADINDEX, 1'b0, 1'b1}},
        '{0, 9'd0,   '{CMD_PEEK, 32'hFFFF_FFFF, 9'h1FF}, 1, '{ERR_WORD, STS_BADINDEX, 1'b0, 1'b1}},
        '{1, 9'd1,   '{CMD_PUSH, 32'h0000_0000, 9'd0},   1, '{32'd0, STS_OVERFLOW, 1'b0, 1'b1}},
        '{0, 9'd0,   '{CMD_POP,  32'h0000_0000, 9'd0},   0, NO_RSP},
        '{0, 9'd0,   '{CMD_POP,  32'h0000_0000, 9'd0},   0, NO_RSP},
        '{0, 9'd0,   '{CMD_POP,  32'h0000_0000, 9'd0},   1, '{ERR_WORD, STS_UNDERFLOW, 1'b1, 1'b0}},
        '{1, 9'h1FF, '{CMD_PUSH, 32'h0000_0001, 9'd0},   0, NO_RSP},
        '{0, 9'd0,   '{CMD_NOP,  32'h0000_0000, 9'd0},   1, '{32'd0, STS_OK, 1'b0, 1'b0}},
        '{0, 9'd0,   '{CMD_POP,  32'h0000_0000, 9'd0},   0, NO_RSP},
        '{0, 9'd0,   '{CMD_NOP,  32'h0000_0000, 9'd0},   1, '{32'd0, STS_OK, 1'b1, 1'b0}}
    };

    phase_t phases [6] = '{
        '{511, 290, 92,  3,  4},
        '{5,    60, 20, 45, 30},
        '{0,    30, 30, 35, 30},
        '{1,    60, 40, 30, 25},
        '{-1,   80, 40, 35, 20},
        '{256,  80, 40, 35, 20}
    };

    bounded_array_stack_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity_we   (capacity_we),
        .capacity_data (capacity_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp)
    );

    always #2 clk = ~clk;

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic rsp_beat_t stack_apply(req_beat_t b);
        rsp_beat_t r;
        int        lim;
        lim = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
        r   = '0;
        case (b.cmd)
            CMD_PUSH:
            begin
                if (shadow_count >= lim)
                begin
                    r.status = STS_OVERFLOW;
                end
                else
                begin
                    shadow_words[shadow_count] = b.push_value;
                    shadow_count++;
                end
            end
            CMD_POP:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STS_UNDERFLOW;
                    r.data   = ERR_WORD;
                end
                else
                begin
                    shadow_count--;
                    r.data = shadow_words[shadow_count];
                end
            end
            CMD_PEEK:
            begin
                if (b.position == 0 || int'(b.position) > shadow_count)
                begin
                    r.status = STS_BADINDEX;
                    r.data   = ERR_WORD;
                end
                else
                begin
                    r.data = shadow_words[shadow_count - int'(b.position)];
                end
            end
            default:
            begin
            end
        endcase
        r.is_empty = (shadow_count == 0);
        r.is_full  = (shadow_count >= lim);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at response %0d: %s", rsp_seen, msg);
        mismatches++;
    endtask

    task automatic issue_beat(input req_beat_t b, input bit typed, input rsp_beat_t want);
        rsp_beat_t pred;
        req_valid <= 1'b1;
        req       <= b;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        pred = stack_apply(b);
        pending_rsp.push_back(typed ? want : pred);
        if (!send_quiet && $urandom_range(0, 99) < 30)
        begin
            req_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [8:0] v);
        wait_drained();
        capacity_we   <= 1'b1;
        capacity_data <= v;
        @(posedge clk);
        capacity_we <= 1'b0;
        shadow_cap = v;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (!rsp_quiet && $urandom_range(0, 99) < 25)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= idle_len() - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                note_mismatch("response beat with nothing expected");
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.data !== want.data)
                begin
                    note_mismatch($sformatf("data %h, expected %h", rsp.data, want.data));
                end
                if (rsp.status !== want.status)
                begin
                    note_mismatch($sformatf("status %0d, expected %0d", rsp.status,
                                            want.status));
                end
                if (rsp.is_empty !== want.is_empty)
                begin
                    note_mismatch($sformatf("is_empty %b, expected %b", rsp.is_empty,
                                            want.is_empty));
                end
                if (rsp.is_full !== want.is_full)
                begin
                    note_mismatch($sformatf("is_full %b, expected %b", rsp.is_full,
                                            want.is_full));
                end
            end
            rsp_seen++;
        end
    end

    initial
    begin
        req_beat_t b;
        int        r;
        int        pos;
        int        cap;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_cap)
            begin
                write_capacity(dir_rows[i].cap);
            end
            issue_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        foreach (phases[p])
        begin
            cap = (phases[p].cap < 0) ? $urandom_range(2, 20) : phases[p].cap;
            write_capacity(9'(cap));
            send_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet  = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phases[p].beats; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < phases[p].push_pct)
                begin
                    b.cmd = CMD_PUSH;
                end
                else if (r < phases[p].push_pct + phases[p].pop_pct)
                begin
                    b.cmd = CMD_POP;
                end
                else if (r < phases[p].push_pct + phases[p].pop_pct + phases[p].peek_pct)
                begin
                    b.cmd = CMD_PEEK;
                end
                else
                begin
                    b.cmd = CMD_NOP;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: b.push_value = 32'h0000_0000;
                        1: b.push_value = 32'h7FFF_FFFF;
                        2: b.push_value = 32'h8000_0000;
                        default: b.push_value = 32'hFFFF_FFFF;
                    endcase
                end
                else
                begin
                    b.push_value = $urandom;
                end
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    pos = $urandom_range(1, 4);
                end
                else if (r < 75)
                begin
                    pos = (shadow_count == 0) ? 1 : $urandom_range(1, shadow_count);
                end
                else if (r < 85)
                begin
                    pos = $urandom_range(0, 1) ? 0 : shadow_count + 1;
                end
                else
                begin
                    pos = $urandom_range(0, 511);
                end
                b.position = 9'(pos);
                issue_beat(b, 1'b0, NO_RSP);
                if ($urandom_range(0, 99) < 2)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[bounded_array_stack_core] OK");
        end
        else
        begin
            $display("[bounded_array_stack_core] ERROR");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[bounded_array_stack_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bas_pkg.sv
hw/rtl/bas_cell.sv
hw/rtl/bas_ctrl.sv
hw/rtl/bounded_array_stack_core.sv
sim/tb_top.sv
